@@ sv/iosl_pkg.sv @@
package iosl_pkg;

  localparam int KEY_W          = 12;
  localparam int COUNT_W        = 13;
  localparam int NODE_COUNT_DEF = 4096;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_ABSENT = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_LINK  = 5'b01000,
    ST_EMIT  = 5'b10000
  } iosl_state_t;

endpackage

@@ sv/iosl_ram.sv @@
module iosl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/indexed_ordered_set_list.sv @@
// Channel  Direction  Ports
// in       to block   in_valid, in_stall, in_mode, in_node_key
// out      from block out_valid, out_stall, out_status, out_next_key, out_next_valid,
//                     out_head_key, out_tail_key, out_list_count
//
// An append of a new key, a remove, or a no-op goes through these steps: accept with
// the link read, a read-modify-write step, and a load of the result register. A move
// to tail adds a link step before the load: each link memory has one write port and a
// move needs up to two writes into each. After reset a pass over every address clears
// the membership memory; in_stall is high throughout. The next beat is taken while a
// result still waits on a stalled out channel.
module indexed_ordered_set_list import iosl_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [KEY_W-1:0]   in_node_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [KEY_W-1:0]   out_next_key,
  output logic               out_next_valid,
  output logic [KEY_W-1:0]   out_head_key,
  output logic [KEY_W-1:0]   out_tail_key,
  output logic [COUNT_W-1:0] out_list_count
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW = $clog2(NODE_COUNT + 1);

  iosl_state_t        state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               mode_r, mode_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic               rng_r, rng_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               status_r, status_nxt;
  logic [AW-1:0]      nkey_r, nkey_nxt;
  logic               nvalid_r, nvalid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [KEY_W-1:0]   out_next_key_r, out_next_key_nxt;
  logic               out_next_valid_r, out_next_valid_nxt;
  logic [KEY_W-1:0]   out_head_key_r, out_head_key_nxt;
  logic [KEY_W-1:0]   out_tail_key_r, out_tail_key_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic          in_take;
  logic          out_take;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] k;
  logic          p_ok;
  logic          n_ok;

  logic          mem_we, mem_wd, mem_rd;
  logic [AW-1:0] mem_wa;
  logic          bwd_we, fwd_we;
  logic [AW-1:0] bwd_wa, bwd_wd, bwd_rd;
  logic [AW-1:0] fwd_wa, fwd_wd, fwd_rd;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign rd_addr  = AW'(in_node_key);
  assign k        = AW'(key_r);
  assign p_ok     = (k != head_r);
  assign n_ok     = (k != tail_r);

  iosl_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_member (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (rd_addr),
    .rdata (mem_rd)
  );

  iosl_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_prev (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (bwd_wa),
    .wdata (bwd_wd),
    .raddr (rd_addr),
    .rdata (bwd_rd)
  );

  iosl_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_next (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_wa),
    .wdata (fwd_wd),
    .raddr (rd_addr),
    .rdata (fwd_rd)
  );

  always_comb begin
    state_nxt          = state_r;
    clr_nxt            = clr_r;
    mode_nxt           = mode_r;
    key_nxt            = key_r;
    rng_nxt            = rng_r;
    head_nxt           = head_r;
    tail_nxt           = tail_r;
    count_nxt          = count_r;
    status_nxt         = status_r;
    nkey_nxt           = nkey_r;
    nvalid_nxt         = nvalid_r;
    out_valid_nxt      = out_valid_r && !out_take;
    out_status_nxt     = out_status_r;
    out_next_key_nxt   = out_next_key_r;
    out_next_valid_nxt = out_next_valid_r;
    out_head_key_nxt   = out_head_key_r;
    out_tail_key_nxt   = out_tail_key_r;
    out_count_nxt      = out_count_r;
    mem_we             = 1'b0;
    mem_wa             = k;
    mem_wd             = 1'b0;
    bwd_we             = 1'b0;
    bwd_wa             = k;
    bwd_wd             = tail_r;
    fwd_we             = 1'b0;
    fwd_wa             = tail_r;
    fwd_wd             = k;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          mode_nxt  = in_mode;
          key_nxt   = in_node_key;
          rng_nxt   = (32'(in_node_key) < 32'(NODE_COUNT));
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        status_nxt = STAT_OK;
        nkey_nxt   = '0;
        nvalid_nxt = 1'b0;
        state_nxt  = ST_EMIT;
        if (mode_r == MODE_APPEND) begin
          if (rng_r && !mem_rd) begin
            bwd_we    = 1'b1;
            mem_we    = 1'b1;
            mem_wd    = 1'b1;
            tail_nxt  = k;
            count_nxt = count_r + CW'(1);
            if (count_r != '0) begin
              fwd_we = 1'b1;
            end else begin
              head_nxt = k;
            end
          end else if (rng_r && n_ok) begin
            // unlink here, relink at the tail next cycle
            bwd_we = 1'b1;
            bwd_wa = fwd_rd;
            bwd_wd = bwd_rd;
            if (p_ok) begin
              fwd_we = 1'b1;
              fwd_wa = bwd_rd;
              fwd_wd = fwd_rd;
            end else begin
              head_nxt = fwd_rd;
            end
            state_nxt = ST_LINK;
          end
        end else begin
          if (rng_r && mem_rd) begin
            mem_we    = 1'b1;
            count_nxt = count_r - CW'(1);
            fwd_wa    = bwd_rd;
            fwd_wd    = fwd_rd;
            bwd_wa    = fwd_rd;
            bwd_wd    = bwd_rd;
            if (p_ok && n_ok) begin
              fwd_we = 1'b1;
            end
            if (!p_ok) begin
              head_nxt = fwd_rd;
            end
            if (n_ok) begin
              bwd_we     = 1'b1;
              nkey_nxt   = fwd_rd;
              nvalid_nxt = 1'b1;
            end else begin
              tail_nxt = bwd_rd;
            end
          end else begin
            status_nxt = STAT_ABSENT;
          end
        end
      end
      ST_LINK: begin
        bwd_we    = 1'b1;
        fwd_we    = 1'b1;
        tail_nxt  = k;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = status_r;
          out_next_key_nxt   = KEY_W'(nkey_r);
          out_next_valid_nxt = nvalid_r;
          out_head_key_nxt   = (count_r == '0) ? '0 : KEY_W'(head_r);
          out_tail_key_nxt   = (count_r == '0) ? '0 : KEY_W'(tail_r);
          out_count_nxt      = COUNT_W'(count_r);
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r           <= mode_nxt;
    key_r            <= key_nxt;
    rng_r            <= rng_nxt;
    head_r           <= head_nxt;
    tail_r           <= tail_nxt;
    status_r         <= status_nxt;
    nkey_r           <= nkey_nxt;
    nvalid_r         <= nvalid_nxt;
    out_status_r     <= out_status_nxt;
    out_next_key_r   <= out_next_key_nxt;
    out_next_valid_r <= out_next_valid_nxt;
    out_head_key_r   <= out_head_key_nxt;
    out_tail_key_r   <= out_tail_key_nxt;
    out_count_r      <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_next_key   = out_next_key_r;
  assign out_next_valid = out_next_valid_r;
  assign out_head_key   = out_head_key_r;
  assign out_tail_key   = out_tail_key_r;
  assign out_list_count = out_count_r;

endmodule

@@ sv/iosl_chk.sv @@
module iosl_chk import iosl_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_mode,
  input logic [KEY_W-1:0]   in_node_key,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_status,
  input logic [KEY_W-1:0]   out_next_key,
  input logic               out_next_valid,
  input logic [KEY_W-1:0]   out_head_key,
  input logic [KEY_W-1:0]   out_tail_key,
  input logic [COUNT_W-1:0] out_list_count
);

  // one beat in flight: an accepted beat shuts the in channel on the next edge
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("in channel open straight after an accepted beat");

  a_next_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_valid |-> out_status == STAT_OK)
    else $error("successor reported on a failed remove");

  a_next_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_next_valid |-> out_next_key == '0)
    else $error("next_key not zero without a successor");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_next_key)
      && $stable(out_head_key) && $stable(out_tail_key) && $stable(out_list_count))
    else $error("stalled result beat changed");

endmodule

bind indexed_ordered_set_list iosl_chk u_iosl_chk (.*);

@@ bench/indexed_ordered_set_list_tb.sv @@
module indexed_ordered_set_list_tb import iosl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = NODE_COUNT_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 48;

  typedef struct packed {
    logic               status;
    logic [KEY_W-1:0]   next_key;
    logic               next_valid;
    logic [KEY_W-1:0]   head_key;
    logic [KEY_W-1:0]   tail_key;
    logic [COUNT_W-1:0] list_count;
  } fringe_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [KEY_W-1:0]   in_node_key;
  logic               out_valid;
  logic               out_stall;
  logic               out_status;
  logic [KEY_W-1:0]   out_next_key;
  logic               out_next_valid;
  logic [KEY_W-1:0]   out_head_key;
  logic [KEY_W-1:0]   out_tail_key;
  logic [COUNT_W-1:0] out_list_count;

  logic               listed [NODES];
  logic [COUNT_W-1:0] prev_of [NODES];
  logic [COUNT_W-1:0] next_of [NODES];
  logic [COUNT_W-1:0] head_at;
  logic [COUNT_W-1:0] tail_at;
  logic [COUNT_W-1:0] n_listed;

  fringe_result_t pending_results[$];
  fringe_result_t got_res;
  fringe_result_t want_res;
  int             errors     = 0;
  int             cycles     = 0;
  int             stall_left = 0;
  logic           idle_on    = 1'b1;
  int             pool [POOL_SIZE];

  indexed_ordered_set_list u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_node_key   (in_node_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_next_key  (out_next_key),
    .out_next_valid(out_next_valid),
    .out_head_key  (out_head_key),
    .out_tail_key  (out_tail_key),
    .out_list_count(out_list_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit is_node(logic [COUNT_W-1:0] p);
    return int'(p) < NODES;
  endfunction

  function automatic void detach_key(int k);
    logic [COUNT_W-1:0] p;
    logic [COUNT_W-1:0] n;
    p = prev_of[k];
    n = next_of[k];
    if (is_node(p)) next_of[p] = n;
    else head_at = n;
    if (is_node(n)) prev_of[n] = p;
    else tail_at = p;
  endfunction

  function automatic void attach_tail(int k);
    prev_of[k] = tail_at;
    next_of[k] = COUNT_W'(NODES);
    if (is_node(tail_at)) next_of[tail_at] = COUNT_W'(k);
    else head_at = COUNT_W'(k);
    tail_at = COUNT_W'(k);
  endfunction

  function automatic fringe_result_t fringe_apply(logic mode, logic [KEY_W-1:0] key);
    fringe_result_t r;
    int             k;
    logic [COUNT_W-1:0] n;
    r = '0;
    k = int'(key);
    if (mode == MODE_APPEND) begin
      if (k < NODES) begin
        if (!listed[k]) begin
          attach_tail(k);
          listed[k] = 1'b1;
          n_listed++;
        end else if (COUNT_W'(k) != tail_at) begin
          detach_key(k);
          attach_tail(k);
        end
      end
    end else begin
      if (k < NODES && listed[k]) begin
        n = next_of[k];
        detach_key(k);
        listed[k] = 1'b0;
        n_listed--;
        if (is_node(n)) begin
          r.next_key   = n[KEY_W-1:0];
          r.next_valid = 1'b1;
        end
      end else begin
        r.status = STAT_ABSENT;
      end
    end
    r.head_key   = is_node(head_at) ? head_at[KEY_W-1:0] : '0;
    r.tail_key   = is_node(tail_at) ? tail_at[KEY_W-1:0] : '0;
    r.list_count = n_listed;
    return r;
  endfunction

  task automatic clear_fringe();
    for (int i = 0; i < NODES; i++) begin
      listed[i]  = 1'b0;
      prev_of[i] = '0;
      next_of[i] = '0;
    end
    head_at  = COUNT_W'(NODES);
    tail_at  = COUNT_W'(NODES);
    n_listed = '0;
  endtask

  task automatic push_op(logic mode, logic [KEY_W-1:0] key);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_node_key <= key;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(fringe_apply(mode, key));
  endtask

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res = '{out_status, out_next_key, out_next_valid, out_head_key, out_tail_key,
                  out_list_count};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, got_res);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        report_field("status", want_res.status, got_res.status);
        report_field("next_key", want_res.next_key, got_res.next_key);
        report_field("next_valid", want_res.next_valid, got_res.next_valid);
        report_field("head_key", want_res.head_key, got_res.head_key);
        report_field("tail_key", want_res.tail_key, got_res.tail_key);
        report_field("list_count", want_res.list_count, got_res.list_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_special_cases();
    push_op(MODE_REMOVE, 12'h000);
    push_op(MODE_APPEND, 12'h000);
    push_op(MODE_APPEND, 12'hFFF);
    push_op(MODE_APPEND, 12'h555);
    push_op(MODE_APPEND, 12'hAAA);
    push_op(MODE_APPEND, 12'hAAA);
    push_op(MODE_APPEND, 12'h000);
    push_op(MODE_APPEND, 12'h555);
    push_op(MODE_APPEND, 12'h123);
    push_op(MODE_REMOVE, 12'h555);
    push_op(MODE_REMOVE, 12'hFFF);
    push_op(MODE_REMOVE, 12'h123);
    push_op(MODE_REMOVE, 12'h7FF);
    push_op(MODE_REMOVE, 12'hAAA);
    push_op(MODE_REMOVE, 12'h000);
    push_op(MODE_REMOVE, 12'h000);
    push_op(MODE_REMOVE, 12'hFFF);
    push_op(MODE_APPEND, 12'hFFF);
    push_op(MODE_APPEND, 12'h800);
    push_op(MODE_APPEND, 12'hFFF);
    push_op(MODE_REMOVE, 12'h800);
    push_op(MODE_REMOVE, 12'hFFF);
  endtask

  task automatic test_random_ops();
    logic [KEY_W-1:0] key;
    logic             mode;
    int               sel;
    foreach (pool[i]) pool[i] = $urandom_range(0, NODES - 1);
    pool[0] = 0;
    pool[1] = NODES - 1;
    repeat (1400) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) key = KEY_W'(pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (sel < 15) key = head_at[KEY_W-1:0];
      else if (sel < 18) key = tail_at[KEY_W-1:0];
      else key = KEY_W'($urandom_range(0, NODES - 1));
      mode = ($urandom_range(0, 99) < 52) ? MODE_APPEND : MODE_REMOVE;
      push_op(mode, key);
    end
  endtask

  task automatic test_fill_drain();
    repeat (300) push_op(MODE_APPEND, KEY_W'($urandom_range(0, NODES - 1)));
    while (n_listed != 0) begin
      if ($urandom_range(0, 3) == 0) push_op(MODE_APPEND, head_at[KEY_W-1:0]);
      else push_op(MODE_REMOVE, head_at[KEY_W-1:0]);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= MODE_APPEND;
    in_node_key <= '0;
    out_stall   <= 1'b0;
    clear_fringe();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_random_ops();
    idle_on <= 1'b0;
    test_fill_drain();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/iosl_pkg.sv
sv/iosl_ram.sv
sv/indexed_ordered_set_list.sv
sv/iosl_chk.sv
bench/indexed_ordered_set_list_tb.sv
